/* rtl/core/uart_bootloader_command_engine_unit_defines.svh */
// Assertion macros shared by the checker.
`ifndef UART_BOOTLOADER_COMMAND_ENGINE_UNIT_DEFINES_SVH
`define UART_BOOTLOADER_COMMAND_ENGINE_UNIT_DEFINES_SVH
`define UBCE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define UBCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* rtl/core/ubce_pkg.sv */
`timescale 1ns / 1ps
package ubce_pkg;
   localparam logic [7:0] ACK_BYTE  = 8'h79;
   localparam logic [7:0] NACK_BYTE = 8'h1F;
   localparam logic [7:0] CMD_GET   = 8'h00;
   localparam logic [7:0] CMD_VER   = 8'h01;
   localparam logic [7:0] CMD_ID    = 8'h02;
   localparam logic [7:0] CMD_READ  = 8'h11;
   localparam logic [7:0] CMD_GO    = 8'h21;
   localparam logic [7:0] CMD_WRITE = 8'h31;
   localparam logic [7:0] CMD_WIPE  = 8'h43;
   localparam logic [7:0] BYTE_FF   = 8'hFF;
   localparam logic [7:0] VERSION_RESET = 8'h10;
   localparam logic [15:0] ID_RESET = 16'h1234;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [1:0] FUNC_RX      = 2'd0;
   localparam logic [1:0] FUNC_TIMEOUT = 2'd1;
   localparam logic [1:0] FUNC_MEM     = 2'd2;
   localparam logic [1:0] FUNC_NOP     = 2'd3;

   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_JUMP  = 2'd3;

   localparam logic [1:0] REG_VERSION = 2'd0;
   localparam logic [1:0] REG_ID      = 2'd1;
   localparam logic [1:0] REG_PROTECT = 2'd2;

   // Reply kinds handed from the front to the back.
   typedef enum logic [3:0] {
      JOB_GET    = 4'd0,
      JOB_VER    = 4'd1,
      JOB_ID     = 4'd2,
      JOB_ONE    = 4'd3,
      JOB_RDATA  = 4'd4
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   byte_val;
      logic [1:0]   op;
      logic [31:0]  addr;
      logic [7:0]   data;
      logic         tx_valid;
   } job_type;

   function automatic logic [7:0] get_list(input logic [2:0] idx);
      logic [7:0] r;
      case (idx)
         3'd0: r = 8'h00;
         3'd1: r = 8'h01;
         3'd2: r = 8'h02;
         3'd3: r = 8'h11;
         3'd4: r = 8'h21;
         3'd5: r = 8'h31;
         default: r = 8'h43;
      endcase
      return r;
   endfunction
endpackage

/* rtl/core/ubce_front.sv */
`timescale 1ns / 1ps
module ubce_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [1:0]        func,
   input  logic [7:0]        rx_byte,
   input  logic              read_protect,
   input  logic              job_full,
   output logic              in_ready,
   output logic              job_push,
   output ubce_pkg::job_type job
);
   import ubce_pkg::*;

   typedef enum logic [11:0] {
      PH_IDLE    = 12'b000000000001,
      PH_CPL     = 12'b000000000010,
      PH_ADDR    = 12'b000000000100,
      PH_READ_N  = 12'b000000001000,
      PH_READ_NC = 12'b000000010000,
      PH_RDATA   = 12'b000000100000,
      PH_WRITE_N = 12'b000001000000,
      PH_WDATA   = 12'b000010000000,
      PH_WCS     = 12'b000100000000,
      PH_ERASE_N = 12'b001000000000,
      PH_EPAGES  = 12'b010000000000,
      PH_ECS     = 12'b100000000000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  code_ff, code_in;
   logic [31:0] addr_ff, addr_in;
   logic [7:0]  xor_ff, xor_in;
   logic [8:0]  left_ff, left_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        fire;
   logic [8:0]  left_dec;

   assign in_ready = !job_full;
   assign fire = in_valid && !job_full;
   assign left_dec = (left_ff != 9'd0) ? left_ff - 9'd1 : 9'd0;

   always_comb begin
      phase_in = phase_ff;
      code_in  = code_ff;
      addr_in  = addr_ff;
      xor_in   = xor_ff;
      left_in  = left_ff;
      cnt_in   = cnt_ff;
      job_push = 1'b0;
      job = '{kind: JOB_ONE, byte_val: ACK_BYTE, op: OP_NONE, addr: 32'd0,
              data: 8'd0, tx_valid: 1'b1};
      if (fire && func != FUNC_NOP) begin
         if (phase_ff == PH_RDATA) begin
            if (func == FUNC_MEM) begin
               job_push = 1'b1;
               job.kind = JOB_RDATA;
               job.byte_val = rx_byte;
               left_in = left_dec;
               addr_in = addr_ff + 32'd1;
               if (left_dec != 9'd0) begin
                  job.op = OP_READ;
                  job.addr = addr_ff + 32'd1;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         end else if (func == FUNC_TIMEOUT) begin
            phase_in = PH_IDLE;
            if (phase_ff inside {PH_ADDR, PH_READ_N, PH_READ_NC, PH_WRITE_N, PH_WDATA,
                                 PH_WCS}) begin
               job_push = 1'b1;
               job.byte_val = NACK_BYTE;
            end
         end else if (func == FUNC_RX) begin
            unique case (phase_ff)
               PH_IDLE: begin
                  code_in = rx_byte;
                  phase_in = PH_CPL;
               end
               PH_CPL: begin
                  job_push = 1'b1;
                  phase_in = PH_IDLE;
                  if ((code_ff ^ rx_byte) != BYTE_FF) begin
                     job.byte_val = NACK_BYTE;
                  end else begin
                     case (code_ff) inside
                        CMD_GET: job.kind = JOB_GET;
                        CMD_VER: job.kind = JOB_VER;
                        CMD_ID:  job.kind = JOB_ID;
                        CMD_READ, CMD_GO, CMD_WRITE, CMD_WIPE: begin
                           if (read_protect) begin
                              job.byte_val = NACK_BYTE;
                           end else if (code_ff == CMD_WIPE) begin
                              phase_in = PH_ERASE_N;
                           end else begin
                              phase_in = PH_ADDR;
                              addr_in = 32'd0;
                              xor_in = 8'd0;
                              cnt_in = 3'd0;
                           end
                        end
                        default: job.byte_val = NACK_BYTE;
                     endcase
                  end
               end
               PH_ADDR: begin
                  if (cnt_ff < 3'd4) begin
                     addr_in = {addr_ff[23:0], rx_byte};
                     xor_in = xor_ff ^ rx_byte;
                     cnt_in = cnt_ff + 3'd1;
                  end else begin
                     job_push = 1'b1;
                     phase_in = PH_IDLE;
                     if (xor_ff != rx_byte) begin
                        job.byte_val = NACK_BYTE;
                     end else if (code_ff == CMD_GO) begin
                        job.op = OP_JUMP;
                        job.addr = addr_ff;
                     end else begin
                        phase_in = (code_ff == CMD_READ) ? PH_READ_N : PH_WRITE_N;
                     end
                  end
               end
               PH_READ_N: begin
                  xor_in = rx_byte;
                  phase_in = PH_READ_NC;
               end
               PH_READ_NC: begin
                  job_push = 1'b1;
                  if ((xor_ff ^ rx_byte) != BYTE_FF) begin
                     phase_in = PH_IDLE;
                     job.byte_val = NACK_BYTE;
                  end else begin
                     left_in = {1'b0, xor_ff} + 9'd1;
                     phase_in = PH_RDATA;
                     job.op = OP_READ;
                     job.addr = addr_ff;
                  end
               end
               PH_WRITE_N: begin
                  xor_in = rx_byte;
                  left_in = {1'b0, rx_byte} + 9'd1;
                  phase_in = PH_WDATA;
               end
               PH_WDATA: begin
                  job_push = 1'b1;
                  job.tx_valid = 1'b0;
                  job.byte_val = 8'd0;
                  job.op = OP_WRITE;
                  job.addr = addr_ff;
                  job.data = rx_byte;
                  xor_in = xor_ff ^ rx_byte;
                  addr_in = addr_ff + 32'd1;
                  left_in = left_dec;
                  if (left_dec == 9'd0) phase_in = PH_WCS;
               end
               PH_WCS: begin
                  job_push = 1'b1;
                  phase_in = PH_IDLE;
                  job.byte_val = (xor_ff == rx_byte) ? ACK_BYTE : NACK_BYTE;
               end
               PH_ERASE_N: begin
                  if (rx_byte == BYTE_FF) begin
                     phase_in = PH_IDLE;
                  end else begin
                     xor_in = rx_byte;
                     left_in = {1'b0, rx_byte} + 9'd1;
                     phase_in = PH_EPAGES;
                  end
               end
               PH_EPAGES: begin
                  xor_in = xor_ff ^ rx_byte;
                  left_in = left_dec;
                  if (left_dec == 9'd0) phase_in = PH_ECS;
               end
               PH_ECS: phase_in = PH_IDLE;
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         code_ff  <= 8'd0;
         addr_ff  <= 32'd0;
         xor_ff   <= 8'd0;
         left_ff  <= 9'd0;
         cnt_ff   <= 3'd0;
      end else begin
         phase_ff <= phase_in;
         code_ff  <= code_in;
         addr_ff  <= addr_in;
         xor_ff   <= xor_in;
         left_ff  <= left_in;
         cnt_ff   <= cnt_in;
      end
   end
endmodule

/* rtl/core/ubce_queue.sv */
`timescale 1ns / 1ps
module ubce_queue #(
   parameter int DEPTH = ubce_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ubce_pkg::job_type wdata,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output ubce_pkg::job_type rdata
);
   import ubce_pkg::*;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   job_type          mem_ff [DEPTH];
   logic [AW-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full  = (cnt_ff == (AW+1)'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign rdata = mem_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      if (do_push) wp_in = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      if (do_pop)  rp_in = (rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      cnt_in = cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wp_ff] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

/* rtl/core/ubce_back.sv */
`timescale 1ns / 1ps
module ubce_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_empty,
   input  ubce_pkg::job_type job,
   output logic              job_pop,
   input  logic [7:0]        boot_version,
   input  logic [15:0]       product_id,
   output logic              out_empty,
   input  logic              out_pop,
   output logic              tx_valid,
   output logic [7:0]        tx_byte,
   output logic [1:0]        mem_op,
   output logic [31:0]       mem_addr,
   output logic [7:0]        mem_data,
   output logic              last
);
   import ubce_pkg::*;

   logic [3:0]  seq_ff, seq_in;
   logic        full_ff, full_in;
   logic        txv_ff, txv_in;
   logic [7:0]  txb_ff, txb_in;
   logic [1:0]  op_ff, op_in;
   logic [31:0] addr_ff, addr_in;
   logic [7:0]  data_ff, data_in;
   logic        last_ff, last_in;
   logic        load;
   logic [3:0]  seq_len;
   logic [7:0]  cur;

   assign out_empty = !full_ff;
   assign tx_valid = txv_ff;
   assign tx_byte = txb_ff;
   assign mem_op = op_ff;
   assign mem_addr = addr_ff;
   assign mem_data = data_ff;
   assign last = last_ff;
   assign load = !job_empty && (!full_ff || out_pop);

   always_comb begin
      seq_len = 4'd0;
      cur = job.byte_val;
      case (job.kind)
         JOB_GET: begin
            seq_len = 4'd10;
            case (seq_ff)
               4'd0, 4'd10: cur = ACK_BYTE;
               4'd1: cur = 8'd7;
               4'd2: cur = boot_version;
               default: cur = get_list(3'(seq_ff - 4'd3));
            endcase
         end
         JOB_VER: begin
            seq_len = 4'd2;
            cur = (seq_ff == 4'd1) ? boot_version : ACK_BYTE;
         end
         JOB_ID: begin
            seq_len = 4'd4;
            case (seq_ff)
               4'd1: cur = 8'd1;
               4'd2: cur = product_id[15:8];
               4'd3: cur = product_id[7:0];
               default: cur = ACK_BYTE;
            endcase
         end
         default: seq_len = 4'd0;
      endcase
   end

   always_comb begin
      seq_in = seq_ff;
      full_in = full_ff && !out_pop;
      job_pop = 1'b0;
      txv_in = txv_ff;
      txb_in = txb_ff;
      op_in = op_ff;
      addr_in = addr_ff;
      data_in = data_ff;
      last_in = last_ff;
      if (load) begin
         full_in = 1'b1;
         txv_in = job.tx_valid;
         txb_in = cur;
         op_in = job.op;
         addr_in = job.addr;
         data_in = job.data;
         last_in = (seq_ff == seq_len);
         if (seq_ff == seq_len) begin
            seq_in = 4'd0;
            job_pop = 1'b1;
         end else begin
            seq_in = seq_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= 4'd0;
         full_ff <= 1'b0;
      end else begin
         seq_ff <= seq_in;
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      txv_ff <= txv_in;
      txb_ff <= txb_in;
      op_ff <= op_in;
      addr_ff <= addr_in;
      data_ff <= data_in;
      last_ff <= last_in;
   end
endmodule

/* rtl/core/uart_bootloader_command_engine_unit.sv */
// UART bootloader command engine. Events enter as queue pushes (received byte, receive
// timeout, returned memory byte) and leave as result beats carrying a byte to send and/or
// a memory operation; the last beat of each event is marked. A new event is taken every
// cycle while the internal job queue has room. The reply sequencer expands each job into
// its result beats, one to eleven per event (eleven for get), and stalls while a beat
// waits unpopped; events without results push no job.
`timescale 1ns / 1ps
module uart_bootloader_command_engine_unit #(
   parameter int QDEPTH = ubce_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_rx_byte,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic [1:0]  rsp_mem_op,
   output logic [31:0] rsp_mem_addr,
   output logic [7:0]  rsp_mem_data,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import ubce_pkg::*;

   logic [7:0]  version_ff;
   logic [15:0] id_ff;
   logic        protect_ff;
   logic        in_ready, job_push, job_full, job_pop, job_empty;
   job_type     job_w, job_r;

   assign pready = 1'b1;
   assign full = !in_ready;

   always_comb begin
      case (paddr[3:2])
         REG_VERSION: prdata = {24'd0, version_ff};
         REG_ID:      prdata = {16'd0, id_ff};
         REG_PROTECT: prdata = {31'd0, protect_ff};
         default:     prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= VERSION_RESET;
         id_ff <= ID_RESET;
         protect_ff <= 1'b0;
      end else if (psel && penable && pwrite && pready) begin
         case (paddr[3:2])
            REG_VERSION: version_ff <= pwdata[7:0];
            REG_ID:      id_ff <= pwdata[15:0];
            REG_PROTECT: protect_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   ubce_front u_front (
      .clock, .reset, .in_valid(push), .func(req_func), .rx_byte(req_rx_byte),
      .read_protect(protect_ff), .job_full, .in_ready, .job_push, .job(job_w)
   );

   ubce_queue #(.DEPTH(QDEPTH)) u_queue (
      .clock, .reset, .push(job_push), .wdata(job_w), .full(job_full),
      .pop(job_pop), .empty(job_empty), .rdata(job_r)
   );

   ubce_back u_back (
      .clock, .reset, .job_empty, .job(job_r), .job_pop,
      .boot_version(version_ff), .product_id(id_ff),
      .out_empty(empty), .out_pop(pop),
      .tx_valid(rsp_tx_valid), .tx_byte(rsp_tx_byte), .mem_op(rsp_mem_op),
      .mem_addr(rsp_mem_addr), .mem_data(rsp_mem_data), .last(rsp_last)
   );
endmodule

/* rtl/core/ubce_checker.sv */
`timescale 1ns / 1ps
`include "uart_bootloader_command_engine_unit_defines.svh"
module ubce_checker (
   input logic        clock,
   input logic        reset,
   input logic        empty,
   input logic        pop,
   input logic        rsp_tx_valid,
   input logic [7:0]  rsp_tx_byte,
   input logic [1:0]  rsp_mem_op,
   input logic [7:0]  rsp_mem_data
);
   import ubce_pkg::*;
   logic stall;
   logic silent;

   assign stall = !empty && !pop;
   assign silent = !empty && !rsp_tx_valid;

   `UBCE_ASSERT_NEXT(a_hold, clock, reset, stall, !empty && $stable(rsp_tx_byte), "beat moved")
   `UBCE_ASSERT_IMPL(a_silent, clock, reset, silent, rsp_mem_op == OP_WRITE, "bad silent beat")
   `UBCE_ASSERT_IMPL(a_sbyte, clock, reset, silent, rsp_tx_byte == 8'd0, "byte on silent beat")
   `UBCE_ASSERT_IMPL(a_wdata, clock, reset, !empty && rsp_mem_op != OP_WRITE, rsp_mem_data == 8'd0, "data")
   `UBCE_ASSERT_NEXT(a_reset, clock, 1'b0, reset, empty, "beat waiting after reset")
endmodule

bind uart_bootloader_command_engine_unit ubce_checker u_checker (
   .clock, .reset, .empty, .pop, .rsp_tx_valid, .rsp_tx_byte, .rsp_mem_op, .rsp_mem_data
);

/* dv/tb.sv */
`timescale 1ns / 1ps
module tb;
   import ubce_pkg::*;

   typedef enum int {
      P_IDLE, P_CPL, P_ADDR, P_READ_N, P_READ_NC, P_READ_DATA,
      P_WRITE_N, P_WRITE_DATA, P_WRITE_CS, P_ERASE_N, P_ERASE_PAGES, P_ERASE_CS
   } boot_phase_type;

   typedef struct {
      logic [1:0] func;
      logic [7:0] data;
   } event_type;

   typedef struct {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic [1:0]  op;
      logic [31:0] addr;
      logic [7:0]  data;
      logic        last;
   } beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [1:0]  req_func = '0;
   logic [7:0]  req_rx_byte = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic        rsp_tx_valid;
   logic [7:0]  rsp_tx_byte;
   logic [1:0]  rsp_mem_op;
   logic [31:0] rsp_mem_addr;
   logic [7:0]  rsp_mem_data;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   uart_bootloader_command_engine_unit u_dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_func(req_func), .req_rx_byte(req_rx_byte), .empty(empty), .pop(pop),
      .rsp_tx_valid(rsp_tx_valid), .rsp_tx_byte(rsp_tx_byte), .rsp_mem_op(rsp_mem_op),
      .rsp_mem_addr(rsp_mem_addr), .rsp_mem_data(rsp_mem_data), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   event_type   pending_events[$];
   beat_type    expected_beats[$];
   int          send_idle = 0;
   int          recv_idle = 0;
   int          errors = 0;
   int          beats_seen = 0;
   int          events_taken = 0;

   logic [7:0]  boot_ver = VERSION_RESET;
   logic [15:0] prod_id = ID_RESET;
   logic        rd_prot = 1'b0;
   boot_phase_type ph = P_IDLE;
   logic [7:0]  cmd_q = '0;
   logic [31:0] addr_acc = '0;
   logic [7:0]  xsum = '0;
   logic [8:0]  left = '0;
   logic [2:0]  nbytes = '0;

   const logic [7:0] get_codes[7] = '{CMD_GET, CMD_VER, CMD_ID, CMD_READ, CMD_GO,
                                       CMD_WRITE, CMD_WIPE};

   function automatic beat_type mk(logic v, logic [7:0] tb_byte, logic [1:0] op,
                                   logic [31:0] a, logic [7:0] d);
      beat_type r;
      r.tx_valid = v;
      r.tx_byte = tb_byte;
      r.op = op;
      r.addr = a;
      r.data = d;
      r.last = 1'b0;
      return r;
   endfunction

   function automatic void predict_replies(logic [1:0] f, logic [7:0] b);
      beat_type q[$];
      if (f == FUNC_NOP) return;
      if (ph == P_READ_DATA) begin
         if (f != FUNC_MEM) return;
         if (left > 0) left--;
         addr_acc++;
         if (left > 0) begin
            q.push_back(mk(1, b, OP_READ, addr_acc, 0));
         end else begin
            q.push_back(mk(1, b, OP_NONE, 0, 0));
            ph = P_IDLE;
         end
      end else if (f == FUNC_MEM) begin
         return;
      end else if (f == FUNC_TIMEOUT) begin
         if (ph inside {P_ADDR, P_READ_N, P_READ_NC, P_WRITE_N, P_WRITE_DATA, P_WRITE_CS})
            q.push_back(mk(1, NACK_BYTE, OP_NONE, 0, 0));
         ph = P_IDLE;
      end else begin
         case (ph)
            P_IDLE: begin
               cmd_q = b;
               ph = P_CPL;
            end
            P_CPL: begin
               ph = P_IDLE;
               if ((cmd_q ^ b) != BYTE_FF) begin
                  q.push_back(mk(1, NACK_BYTE, OP_NONE, 0, 0));
               end else if (cmd_q == CMD_GET) begin
                  q.push_back(mk(1, ACK_BYTE, OP_NONE, 0, 0));
                  q.push_back(mk(1, 8'd7, OP_NONE, 0, 0));
                  q.push_back(mk(1, boot_ver, OP_NONE, 0, 0));
                  foreach (get_codes[i]) q.push_back(mk(1, get_codes[i], OP_NONE, 0, 0));
                  q.push_back(mk(1, ACK_BYTE, OP_NONE, 0, 0));
               end else if (cmd_q == CMD_VER) begin
                  q.push_back(mk(1, ACK_BYTE, OP_NONE, 0, 0));
                  q.push_back(mk(1, boot_ver, OP_NONE, 0, 0));
                  q.push_back(mk(1, ACK_BYTE, OP_NONE, 0, 0));
               end else if (cmd_q == CMD_ID) begin
                  q.push_back(mk(1, ACK_BYTE, OP_NONE, 0, 0));
                  q.push_back(mk(1, 8'd1, OP_NONE, 0, 0));
                  q.push_back(mk(1, prod_id[15:8], OP_NONE, 0, 0));
                  q.push_back(mk(1, prod_id[7:0], OP_NONE, 0, 0));
                  q.push_back(mk(1, ACK_BYTE, OP_NONE, 0, 0));
               end else if (!(cmd_q inside {CMD_READ, CMD_GO, CMD_WRITE, CMD_WIPE})
                            || rd_prot) begin
                  q.push_back(mk(1, NACK_BYTE, OP_NONE, 0, 0));
               end else begin
                  if (cmd_q == CMD_WIPE) begin
                     ph = P_ERASE_N;
                  end else begin
                     ph = P_ADDR;
                     addr_acc = '0;
                     xsum = '0;
                     nbytes = '0;
                  end
                  q.push_back(mk(1, ACK_BYTE, OP_NONE, 0, 0));
               end
            end
            P_ADDR: begin
               if (nbytes < 4) begin
                  addr_acc = {addr_acc[23:0], b};
                  xsum ^= b;
                  nbytes++;
               end else begin
                  ph = P_IDLE;
                  if (xsum != b) begin
                     q.push_back(mk(1, NACK_BYTE, OP_NONE, 0, 0));
                  end else if (cmd_q == CMD_GO) begin
                     q.push_back(mk(1, ACK_BYTE, OP_JUMP, addr_acc, 0));
                  end else begin
                     ph = (cmd_q == CMD_READ) ? P_READ_N : P_WRITE_N;
                     q.push_back(mk(1, ACK_BYTE, OP_NONE, 0, 0));
                  end
               end
            end
            P_READ_N: begin
               xsum = b;
               ph = P_READ_NC;
            end
            P_READ_NC: begin
               if ((xsum ^ b) != BYTE_FF) begin
                  ph = P_IDLE;
                  q.push_back(mk(1, NACK_BYTE, OP_NONE, 0, 0));
               end else begin
                  left = xsum + 9'd1;
                  ph = P_READ_DATA;
                  q.push_back(mk(1, ACK_BYTE, OP_READ, addr_acc, 0));
               end
            end
            P_WRITE_N: begin
               xsum = b;
               left = b + 9'd1;
               ph = P_WRITE_DATA;
            end
            P_WRITE_DATA: begin
               q.push_back(mk(0, 0, OP_WRITE, addr_acc, b));
               xsum ^= b;
               addr_acc++;
               if (left > 0) left--;
               if (left == 0) ph = P_WRITE_CS;
            end
            P_WRITE_CS: begin
               ph = P_IDLE;
               q.push_back(mk(1, (xsum == b) ? ACK_BYTE : NACK_BYTE, OP_NONE, 0, 0));
            end
            P_ERASE_N: begin
               if (b == BYTE_FF) begin
                  ph = P_IDLE;
               end else begin
                  xsum = b;
                  left = b + 9'd1;
                  ph = P_ERASE_PAGES;
               end
            end
            P_ERASE_PAGES: begin
               xsum ^= b;
               if (left > 0) left--;
               if (left == 0) ph = P_ERASE_CS;
            end
            default: ph = P_IDLE;
         endcase
      end
      if (q.size() > 0) begin
         q[$].last = 1'b1;
         foreach (q[i]) expected_beats.push_back(q[i]);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            predict_replies(req_func, req_rx_byte);
            events_taken++;
         end
         if (!push || !full) begin
            if (pending_events.size() > 0 && $urandom_range(99) >= send_idle) begin
               push <= 1'b1;
               req_func <= pending_events[0].func;
               req_rx_byte <= pending_events[0].data;
               void'(pending_events.pop_front());
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      beat_type e;
      if (!reset && pop && !empty) begin
         beats_seen++;
         if (expected_beats.size() == 0) begin
            $error("unexpected beat: tx_byte %h op %0d", rsp_tx_byte, rsp_mem_op);
            errors++;
         end else begin
            e = expected_beats.pop_front();
            if (rsp_tx_valid !== e.tx_valid) begin
               $error("tx_valid expected %0d got %0d", e.tx_valid, rsp_tx_valid);
               errors++;
            end
            if (rsp_tx_byte !== e.tx_byte) begin
               $error("tx_byte expected %h got %h", e.tx_byte, rsp_tx_byte);
               errors++;
            end
            if (rsp_mem_op !== e.op) begin
               $error("mem_op expected %0d got %0d", e.op, rsp_mem_op);
               errors++;
            end
            if (rsp_mem_addr !== e.addr) begin
               $error("mem_addr expected %h got %h", e.addr, rsp_mem_addr);
               errors++;
            end
            if (rsp_mem_data !== e.data) begin
               $error("mem_data expected %h got %h", e.data, rsp_mem_data);
               errors++;
            end
            if (rsp_last !== e.last) begin
               $error("last expected %0d got %0d", e.last, rsp_last);
               errors++;
            end
         end
      end
      pop <= ($urandom_range(99) >= recv_idle);
   end

   task automatic add(logic [1:0] f, logic [7:0] b);
      event_type ev;
      ev.func = f;
      ev.data = b;
      pending_events.push_back(ev);
   endtask

   task automatic send_cmd(logic [7:0] c);
      add(FUNC_RX, c);
      add(FUNC_RX, ~c);
   endtask

   task automatic send_addr(logic [31:0] a, bit bad);
      logic [7:0] x;
      x = a[31:24] ^ a[23:16] ^ a[15:8] ^ a[7:0];
      for (int i = 3; i >= 0; i--) add(FUNC_RX, a[8*i +: 8]);
      add(FUNC_RX, bad ? x ^ 8'($urandom_range(1, 255)) : x);
   endtask

   function automatic logic [31:0] pick_addr();
      return ($urandom_range(7) == 0) ? 32'hFFFF_FFFF - $urandom_range(3) : $urandom;
   endfunction

   function automatic logic [7:0] pick_count();
      return ($urandom_range(29) == 0) ? 8'($urandom_range(20, 255)) : 8'($urandom_range(7));
   endfunction

   task automatic seq_read(logic [31:0] a, logic [7:0] n, bit bad_cpl);
      send_cmd(CMD_READ);
      send_addr(a, 0);
      add(FUNC_RX, n);
      add(FUNC_RX, bad_cpl ? n : ~n);
      for (int i = 0; i <= n; i++) begin
         if ($urandom_range(15) == 0) add(FUNC_RX, $urandom);
         add(FUNC_MEM, $urandom);
      end
   endtask

   task automatic seq_write(logic [31:0] a, logic [7:0] n, bit bad_cs);
      logic [7:0] x;
      logic [7:0] d;
      x = n;
      send_cmd(CMD_WRITE);
      send_addr(a, 0);
      add(FUNC_RX, n);
      for (int i = 0; i <= n; i++) begin
         d = $urandom;
         x ^= d;
         add(FUNC_RX, d);
      end
      add(FUNC_RX, bad_cs ? ~x : x);
   endtask

   task automatic seq_erase(logic [7:0] n);
      send_cmd(CMD_WIPE);
      add(FUNC_RX, n);
      if (n != BYTE_FF) begin
         for (int i = 0; i <= n; i++) add(FUNC_RX, $urandom);
         add(FUNC_RX, $urandom);
      end
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] v);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_VERSION: boot_ver = v[7:0];
         REG_ID: prod_id = v[15:0];
         default: rd_prot = v[0];
      endcase
   endtask

   task automatic drain();
      while (pending_events.size() > 0 || push || expected_beats.size() > 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic random_traffic(int n);
      int goal;
      goal = events_taken + pending_events.size() + n;
      while (events_taken + pending_events.size() < goal) begin
         case ($urandom_range(11))
            0: send_cmd(CMD_GET);
            1: send_cmd(CMD_VER);
            2: send_cmd(CMD_ID);
            3: seq_read(pick_addr(), pick_count(), $urandom_range(9) == 0);
            4: begin
               send_cmd(CMD_GO);
               send_addr(pick_addr(), $urandom_range(5) == 0);
            end
            5: seq_write(pick_addr(), pick_count(), $urandom_range(3) == 0);
            6: seq_erase(($urandom_range(3) == 0) ? BYTE_FF : pick_count());
            7: begin
               add(FUNC_RX, $urandom);
               add(FUNC_RX, $urandom);
            end
            8: begin
               send_cmd($urandom_range(1) ? CMD_READ : CMD_WRITE);
               repeat ($urandom_range(6)) add(FUNC_RX, $urandom);
               add(FUNC_TIMEOUT, $urandom);
            end
            9: add(FUNC_NOP, $urandom);
            10: add(FUNC_MEM, $urandom);
            default: begin
               add(FUNC_RX, $urandom);
               add(FUNC_TIMEOUT, $urandom);
            end
         endcase
         @(negedge clock);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      send_idle = 35;
      recv_idle = 56;
      @(negedge clock);
      send_cmd(CMD_GET);
      send_cmd(CMD_VER);
      send_cmd(CMD_ID);
      seq_read(32'hFFFF_FFFF, 8'd1, 0);
      send_cmd(CMD_GO);
      send_addr(32'h0800_0000, 0);
      seq_write(32'h2000_0000, 8'd0, 0);
      seq_write(32'h2000_0010, 8'd1, 1);
      seq_erase(BYTE_FF);
      seq_erase(8'd0);
      add(FUNC_RX, CMD_GET);
      add(FUNC_RX, 8'h00);
      send_cmd(8'h55);
      send_cmd(CMD_GO);
      send_addr(32'h1234_5678, 1);
      add(FUNC_RX, CMD_VER);
      add(FUNC_TIMEOUT, 8'h00);
      add(FUNC_MEM, 8'hA5);
      add(FUNC_NOP, 8'h5A);
      add(FUNC_TIMEOUT, 8'hFF);
      drain();
      for (int seg = 0; seg < 6; seg++) begin
         if (seg == 2) begin
            send_idle = 56;
            recv_idle = 35;
         end else if (seg == 4) begin
            send_idle = 0;
            recv_idle = 0;
         end
         case (seg)
            1: begin
               csr_write(REG_VERSION, 32'h0);
               csr_write(REG_ID, 32'h0);
               csr_write(REG_PROTECT, 32'h1);
            end
            2: begin
               csr_write(REG_VERSION, 32'hFF);
               csr_write(REG_ID, 32'hFFFF);
               csr_write(REG_PROTECT, 32'h0);
            end
            3: begin
               csr_write(REG_VERSION, $urandom);
               csr_write(REG_PROTECT, 32'h1);
            end
            4: begin
               csr_write(REG_ID, $urandom);
               csr_write(REG_PROTECT, 32'h0);
            end
            5: csr_write(REG_VERSION, $urandom);
            default: ;
         endcase
         @(negedge clock);
         random_traffic(42);
         drain();
      end
      $display("Covered %0d events and %0d result beats over six register settings,",
               events_taken, beats_seen);
      $display("with sender and receiver stalls swapped and then removed.");
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end
endmodule
